// ===== rtl/bank_run_allocator_top_defines.svh =====
// Assertion macros shared by the bank run allocator RTL.
`ifndef BANK_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define BANK_RUN_ALLOCATOR_TOP_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define BRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/bra_pkg.sv =====
// Package for the bank run allocator: sizes, command and status codes, tag reset values, cell control type.
package bra_pkg;
  localparam int unsigned BankCount = 64;
  localparam int unsigned BankBytes = 4096;

  localparam logic [2:0] CMD_SEEK    = 3'd0;
  localparam logic [2:0] CMD_CLAIM   = 3'd1;
  localparam logic [2:0] CMD_RANGE   = 3'd2;
  localparam logic [2:0] CMD_OUTPUT  = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RUN   = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_NOT_CONT = 2'd3;

  localparam logic [7:0] HeadTagRst = 8'd56;
  localparam logic [7:0] ContTagRst = 8'd55;

  // Control broadcast from the sequencer to every bank cell.
  typedef struct packed {
    logic       write;
    logic       release_m;
    logic [7:0] tag;
  } cell_ctl_t;
endpackage

// ===== rtl/bra_cell.sv =====
// One bank cell: holds a bank's free flag, owner and tag, and passes its entry along the ring.
module bra_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  logic              in_free,
  input  logic [63:0]       in_hi,
  input  logic [63:0]       in_lo,
  input  logic [7:0]        in_arg,
  input  logic              upd,
  input  bra_pkg::cell_ctl_t ctl,
  input  logic [63:0]       id_hi,
  input  logic [63:0]       id_lo,
  output logic              free_o,
  output logic [63:0]       hi_o,
  output logic [63:0]       lo_o,
  output logic [7:0]        arg_o
);
  logic free_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0] arg_r;

  // Rotate entry into this cell; the head cell may rewrite it on the way.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b1;
    end else if (shift) begin
      if (upd && ctl.write) begin
        free_r <= 1'b0;
      end else if (upd && ctl.release_m && !in_free && in_hi == id_hi && in_lo == id_lo
                   && in_arg == ctl.tag) begin
        free_r <= 1'b1;
      end else begin
        free_r <= in_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      if (upd && ctl.write) begin
        hi_r  <= id_hi;
        lo_r  <= id_lo;
        arg_r <= ctl.tag;
      end else begin
        hi_r  <= in_hi;
        lo_r  <= in_lo;
        arg_r <= in_arg;
      end
    end
  end

  assign free_o = free_r;
  assign hi_o   = hi_r;
  assign lo_o   = lo_r;
  assign arg_o  = arg_r;
endmodule

// ===== rtl/bank_run_allocator_top.sv =====
// Bank run allocator top level: ring of bank cells plus a one-entry-per-cycle scan sequencer.
// A word is accepted in idle, the ring then rotates one full turn (one scan step per bank) and
// the result state follows. Claim rotates two turns, a check pass and a write pass, before
// its result state.
// The sequencer inspects and updates the entry leaving the last cell each scan cycle.
// The result goes to an output register; the result cycle holds while an earlier result is
// still undelivered, and the next word is taken in the idle cycle that follows it.
`include "bank_run_allocator_top_defines.svh"
module bank_run_allocator_top #(
  parameter int unsigned BANK_COUNT = bra_pkg::BankCount,
  parameter int unsigned BANK_BYTES = bra_pkg::BankBytes
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[2:0], request_size[26:3], first_bank[32:27], owner_id_high[96:33],
  // owner_id_low[160:97], arg_tag[168:161], zero fill to 176
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], run_start[7:2], run_end[13:8], run_length[20:14], zero fill to 24
  output logic [23:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [7:0]   cfg_wdata
);
  localparam int unsigned IW = $clog2(BANK_COUNT);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SH = $clog2(BANK_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [7:0] head_r, cont_r;

  // Latched command word.
  logic [2:0]  cmd_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0]  tag_r;
  logic [5:0]  first_r;
  logic [7:0]  need_r;        // banks needed, saturated at 127 for the length field
  logic        big_r;         // need exceeds bank count
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic          done_r, err_r, fnd_r, claim_ok_r, pass2_r;
  logic [CW-1:0] s_r, e_r;
  logic [1:0]  st_r;
  logic [5:0]  os_r, oe_r;
  logic [6:0]  ol_r;
  logic        ov_r;

  // Ring of cells.
  logic        fr [BANK_COUNT];
  logic [63:0] ch [BANK_COUNT];
  logic [63:0] cl [BANK_COUNT];
  logic [7:0]  ca [BANK_COUNT];
  logic        shift, upd;
  bra_pkg::cell_ctl_t ctl;

  // Size to bank count: shift and round up.
  logic [23:0] size_w;
  logic [24:0] need_w;
  assign size_w = in_tdata[26:3];
  assign need_w = {1'b0, size_w >> SH} + {24'd0, |(size_w & 24'((1 << SH) - 1))};

  genvar g;
  generate
    for (g = 0; g < BANK_COUNT; g++) begin : g_cell
      localparam int unsigned P = (g == 0) ? BANK_COUNT - 1 : g - 1;
      bra_cell u_cell (
        .clk, .rst_n, .shift,
        .in_free(fr[P]), .in_hi(ch[P]), .in_lo(cl[P]), .in_arg(ca[P]),
        .upd(g == 0 ? upd : 1'b0), .ctl, .id_hi(hi_r), .id_lo(lo_r),
        .free_o(fr[g]), .hi_o(ch[g]), .lo_o(cl[g]), .arg_o(ca[g])
      );
    end
  endgenerate

  // Entry under the scan head: the last cell, index idx_r.
  logic        t_free, t_own;
  logic [CW-1:0] i_ext, need_c;
  assign t_free = fr[BANK_COUNT-1];
  assign t_own  = !t_free && ch[BANK_COUNT-1] == hi_r && cl[BANK_COUNT-1] == lo_r;
  assign i_ext  = idx_r;
  assign need_c = CW'(need_r);
  assign shift  = (state_r == S_SCAN);

  // Claim runs two turns: check, then write.
  logic in_claim_rng;
  assign in_claim_rng = !big_r && CW'(first_r) <= i_ext && i_ext < CW'(first_r) + need_c;
  always_comb begin
    ctl.write     = (cmd_r == bra_pkg::CMD_CLAIM) && pass2_r && claim_ok_r && in_claim_rng;
    ctl.release_m = (cmd_r == bra_pkg::CMD_RELEASE);
    ctl.tag       = tag_r;
    upd           = shift;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (idx_r == CW'(BANK_COUNT - 1) &&
                  !(cmd_r == bra_pkg::CMD_CLAIM && !pass2_r)) state_nxt = S_DONE;
      S_DONE: if (!ov_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= bra_pkg::HeadTagRst;
      cont_r  <= bra_pkg::ContTagRst;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && !cfg_addr) head_r <= cfg_wdata;
      if (cfg_we && cfg_addr)  cont_r <= cfg_wdata;
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (state_r == S_DONE && (!ov_r || out_tready)) ov_r <= 1'b1;
    end
  end

  // Scan datapath: one bank per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r   <= in_tdata[2:0];
      first_r <= in_tdata[32:27];
      hi_r    <= in_tdata[96:33];
      lo_r    <= in_tdata[160:97];
      tag_r   <= in_tdata[168:161];
      need_r  <= (need_w > 25'd127) ? 8'd127 : need_w[7:0];
      big_r   <= need_w > 25'(BANK_COUNT);
      idx_r   <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      err_r   <= 1'b0;
      fnd_r   <= 1'b0;
      pass2_r <= 1'b0;
      claim_ok_r <= !(need_w > 25'(BANK_COUNT)) &&
                    (26'(in_tdata[32:27]) + 26'(need_w) <= 26'(BANK_COUNT));
      s_r <= '0;
      e_r <= '1;
    end else if (state_r == S_SCAN) begin
      idx_r <= (idx_r == CW'(BANK_COUNT - 1)) ? '0 : idx_r + 1'b1;
      if (idx_r == CW'(BANK_COUNT - 1)) pass2_r <= 1'b1;
      unique case (cmd_r)
        bra_pkg::CMD_SEEK: if (!done_r && need_r != 8'd0 && !big_r) begin
          if (t_free) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r + 1'b1 == need_c) begin
              done_r <= 1'b1;
              s_r <= i_ext + 1'b1 - need_c;
              e_r <= i_ext;
            end
          end else cnt_r <= '0;
        end
        bra_pkg::CMD_CLAIM: if (!pass2_r && in_claim_rng && !t_free) claim_ok_r <= 1'b0;
        bra_pkg::CMD_RANGE: if (!err_r && t_own && ca[BANK_COUNT-1] == tag_r) begin
          if (!fnd_r) s_r <= i_ext;
          else if (i_ext != e_r + 1'b1) err_r <= 1'b1;
          fnd_r <= 1'b1;
          e_r <= i_ext;
        end
        bra_pkg::CMD_OUTPUT: if (!err_r && t_own) begin
          if (ca[BANK_COUNT-1] == head_r) begin
            s_r <= i_ext; fnd_r <= 1'b1;
          end
          // A bank tagged both head and continuation counts as a break in the run and flags an error.
          if (ca[BANK_COUNT-1] == cont_r) begin
            if (ca[BANK_COUNT-1] == head_r || i_ext != e_r + 1'b1) err_r <= 1'b1;
            e_r <= i_ext;
          end else if (ca[BANK_COUNT-1] == head_r) e_r <= i_ext;
        end
        default: ;
      endcase
    end
  end

  // Result formation.
  always_comb begin
    st_r = bra_pkg::ST_OK;
    os_r = '0; oe_r = '0; ol_r = '0;
    case (cmd_r)
      bra_pkg::CMD_SEEK: begin
        ol_r = need_r[6:0];
        if (need_r == 8'd0) ;
        else if (done_r) begin
          os_r = 6'(s_r); oe_r = 6'(e_r);
        end else st_r = bra_pkg::ST_NO_RUN;
      end
      bra_pkg::CMD_CLAIM: begin
        ol_r = need_r[6:0];
        os_r = first_r;
        oe_r = first_r;
        if (!claim_ok_r) st_r = bra_pkg::ST_NO_RUN;
        else if (need_r != 8'd0) oe_r = 6'(7'(first_r) + need_r[6:0] - 7'd1);
      end
      bra_pkg::CMD_RANGE, bra_pkg::CMD_OUTPUT: begin
        if (err_r) st_r = bra_pkg::ST_NOT_CONT;
        else if (!fnd_r) st_r = bra_pkg::ST_NOT_FND;
        else begin
          os_r = 6'(s_r); oe_r = 6'(e_r);
          ol_r = 7'(e_r - s_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  logic [23:0] out_r;
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!ov_r || out_tready))
      out_r <= {3'd0, ol_r, oe_r, os_r, st_r};
  end
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  `BRA_ASSERT(a_ready_idle, in_tready == (state_r == S_IDLE), "ready outside idle")
  `BRA_ASSERT_NEXT(a_done_out, state_r == S_DONE && state_nxt == S_IDLE, out_tvalid,
                   "result not presented")
  `BRA_ASSERT(a_no_write_pass1, !(ctl.write && !pass2_r), "claim write in check pass")
endmodule
